/* rtl/view_factor_gain_accumulator_defines.svh */
// Assertion macros for the view-factor gain accumulator checker.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef VIEW_FACTOR_GAIN_ACCUMULATOR_DEFINES_SVH
`define VIEW_FACTOR_GAIN_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VFGA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vfga assertion failed");

// Next-cycle implication, disabled during reset.
`define VFGA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vfga assertion failed");

`endif

/* rtl/vfga_pkg.sv */
// Package for the view-factor gain accumulator: codes, constants, item types.
// No dependencies.
`default_nettype none
package vfga_pkg;

    localparam int FRAC_BITS          = 15;
    localparam int ONE                = 1 << FRAC_BITS;
    localparam int HALF               = 1 << (FRAC_BITS - 1);
    localparam int DEF_MAX_ELEMENTS   = 4096;
    localparam int DEF_MAX_MATERIALS  = 256;
    localparam int QUEUE_DEPTH        = 2;
    localparam int ACC_W              = 48;
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [31:0] GAIN_MAX  = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD_MAT  = 2'd0,
        OP_LOAD_ELEM = 2'd1,
        OP_ENTRY     = 2'd2,
        OP_ROW_END   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_GAIN_MODE      = 3'd0,
        CFG_ELEMENT_COUNT  = 3'd1,
        CFG_MATERIAL_COUNT = 3'd2,
        CFG_SUN_X          = 3'd3,
        CFG_SUN_Y          = 3'd4,
        CFG_SUN_Z          = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic               gain_mode;
        logic [12:0]        element_count;
        logic [8:0]         material_count;
        logic signed [15:0] sun_x;
        logic signed [15:0] sun_y;
        logic signed [15:0] sun_z;
    } cfg_t;

    typedef struct packed {
        op_t                kind;
        logic               slot_ok;
        logic [11:0]        slot_index;
        logic [15:0]        material_id;
        logic signed [16:0] absorptivity;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [15:0]        sky_fraction;
        logic [15:0]        visibility;
        logic [15:0]        column_index;
        logic [15:0]        view_factor;
    } item_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MAT,
        BK_ELEM_X,
        BK_ELEM_Y,
        BK_ELEM_Z,
        BK_ELEM_REFL,
        BK_ELEM_MUL1,
        BK_ELEM_MUL2,
        BK_ELEM_WR,
        BK_MAC_MUL,
        BK_MAC_ACC,
        BK_ROW_CHK,
        BK_ROW_EMIT
    } bk_state_t;

endpackage
`default_nettype wire

/* rtl/vfga_if.sv */
// Channel interfaces for the view-factor gain accumulator.
// No dependencies.
`default_nettype none
interface vfga_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [11:0]        slot_index;
    logic [15:0]        material_id;
    logic signed [16:0] absorptivity;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        sky_fraction;
    logic [15:0]        visibility;
    logic [15:0]        column_index;
    logic [15:0]        view_factor;

    modport source (output valid, operation, slot_index, material_id, absorptivity,
                    normal_x, normal_y, normal_z, sky_fraction, visibility,
                    column_index, view_factor, input ready);
    modport sink (input valid, operation, slot_index, material_id, absorptivity,
                  normal_x, normal_y, normal_z, sky_fraction, visibility,
                  column_index, view_factor, output ready);
endinterface

interface vfga_gain_if;
    logic               valid;
    logic               ready;
    logic [11:0]        row_index;
    logic signed [31:0] gain;

    modport source (output valid, row_index, gain, input ready);
    modport sink (input valid, row_index, gain, output ready);
endinterface
`default_nettype wire

/* rtl/vfga_front.sv */
// Front end: accepts item beats, classifies them and queues them for the back end.
// Depends on vfga_pkg and vfga_if.
`default_nettype none
module vfga_front
    import vfga_pkg::*;
#(
    parameter int MAX_ELEMENTS  = DEF_MAX_ELEMENTS,
    parameter int MAX_MATERIALS = DEF_MAX_MATERIALS
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    vfga_item_if.sink  items,
    input  wire logic  pop,
    output logic       q_valid,
    output item_t      q_item
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t           queue_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    item_t           cls_item;
    logic            push;
    logic            do_pop;

    assign items.ready = (count_reg != CW'(QUEUE_DEPTH));
    assign push        = items.valid && items.ready;
    assign q_valid     = (count_reg != '0);
    assign q_item      = queue_reg[rd_ptr_reg];
    assign do_pop      = pop && q_valid;

    // Classify: decode the operation and check the load slot against its store.
    always_comb
    begin
        cls_item.kind         = op_t'(items.operation);
        cls_item.slot_index   = items.slot_index;
        cls_item.material_id  = items.material_id;
        cls_item.absorptivity = items.absorptivity;
        cls_item.normal_x     = items.normal_x;
        cls_item.normal_y     = items.normal_y;
        cls_item.normal_z     = items.normal_z;
        cls_item.sky_fraction = items.sky_fraction;
        cls_item.visibility   = items.visibility;
        cls_item.column_index = items.column_index;
        cls_item.view_factor  = items.view_factor;
        case (op_t'(items.operation))
            OP_LOAD_MAT:  cls_item.slot_ok = 32'(items.slot_index) < 32'(MAX_MATERIALS);
            OP_LOAD_ELEM: cls_item.slot_ok = 32'(items.slot_index) < 32'(MAX_ELEMENTS);
            default:      cls_item.slot_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cls_item;
        end
    end
endmodule
`default_nettype wire

/* rtl/vfga_back.sv */
// Back end: sequencer that runs loads, multiply-accumulates and row ends on the stores.
// Depends on vfga_pkg and vfga_if.
`default_nettype none
module vfga_back
    import vfga_pkg::*;
#(
    parameter int MAX_ELEMENTS  = DEF_MAX_ELEMENTS,
    parameter int MAX_MATERIALS = DEF_MAX_MATERIALS
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   q_valid,
    input  wire item_t  q_item,
    output logic        pop,
    vfga_gain_if.source gains
);
    localparam int EAW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int MAW = (MAX_MATERIALS > 1) ? $clog2(MAX_MATERIALS) : 1;
    localparam int RW  = $clog2(MAX_ELEMENTS + 1);

    logic signed [16:0] absorb_mem [MAX_MATERIALS];
    logic [15:0]        weight_mem [MAX_ELEMENTS];
    logic [15:0]        sky_mem    [MAX_ELEMENTS];

    bk_state_t          state_reg, state_next;
    item_t              item_reg, item_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [RW-1:0]      row_reg, row_next;
    logic signed [31:0] prod_reg, prod_next;
    logic signed [33:0] dot_reg, dot_next;
    logic [16:0]        refl_reg, refl_next;
    logic [33:0]        p1_reg, p1_next;
    logic [19:0]        w1_reg, w1_next;
    logic [35:0]        p2_reg, p2_next;
    logic [31:0]        mac_reg, mac_next;
    logic               col_ok_reg, col_ok_next;
    logic [31:0]        g_reg, g_next;
    logic               out_valid_reg, out_valid_next;
    logic [11:0]        out_row_reg, out_row_next;
    logic [31:0]        out_gain_reg, out_gain_next;

    logic signed [16:0] absorb_rd_reg;
    logic [15:0]        weight_rd_reg;
    logic [15:0]        sky_rd_reg;

    logic [31:0]        n_eff;
    logic [31:0]        m_eff;
    logic               mat_wr;
    logic               elem_wr;
    logic [15:0]        weight_wr;
    logic [31:0]        mat_addr_ext;
    logic [31:0]        col_addr_ext;
    logic [31:0]        row_addr_ext;
    logic [31:0]        slot_ext;
    logic signed [17:0] refl_raw;
    logic               cos_pos;
    logic [18:0]        cos_raw;
    logic [16:0]        cos_sat;
    logic [16:0]        mul_a;
    logic [21:0]        w_sel;
    logic [ACC_W:0]     acc_sum;
    logic [ACC_W:0]     acc_rnd;
    logic [34:0]        g_sum;

    assign n_eff = (32'(cfg.element_count) > 32'(MAX_ELEMENTS)) ?
                   32'(MAX_ELEMENTS) : 32'(cfg.element_count);
    assign m_eff = (32'(cfg.material_count) > 32'(MAX_MATERIALS)) ?
                   32'(MAX_MATERIALS) : 32'(cfg.material_count);

    assign mat_addr_ext = 32'(q_item.material_id);
    assign col_addr_ext = 32'(q_item.column_index);
    assign row_addr_ext = 32'(row_reg);
    assign slot_ext     = 32'(item_reg.slot_index);

    assign pop = (state_reg == BK_IDLE) && q_valid;

    assign gains.valid     = out_valid_reg;
    assign gains.row_index = out_row_reg;
    assign gains.gain      = out_gain_reg;

    // Raw reflectance, sun cosine sign and sun cosine clamped to one.
    assign refl_raw = 18'(ONE) - 18'(absorb_rd_reg);
    assign cos_pos  = (dot_reg > 34'sd0);
    assign cos_raw  = dot_reg[33:15];
    assign cos_sat  = (32'(cos_raw) > 32'(ONE)) ? 17'(ONE) : cos_raw[16:0];
    assign mul_a    = cfg.gain_mode ? cos_sat : 17'(item_reg.sky_fraction);

    always_comb
    begin
        if (cfg.gain_mode)
        begin
            w_sel = cos_pos ? 22'((p2_reg + 36'(HALF)) >> FRAC_BITS) : '0;
        end
        else
        begin
            w_sel = 22'(w1_reg);
        end
        weight_wr = (w_sel > 22'h00FFFF) ? 16'hFFFF : w_sel[15:0];
    end

    assign acc_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(mac_reg);
    assign acc_rnd = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(HALF);
    assign g_sum   = 35'(acc_rnd >> FRAC_BITS) +
                     (cfg.gain_mode ? 35'd0 : 35'(sky_rd_reg));

    assign mat_wr  = (state_reg == BK_MAT) && item_reg.slot_ok;
    assign elem_wr = (state_reg == BK_ELEM_WR) && item_reg.slot_ok;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        acc_next       = acc_reg;
        row_next       = row_reg;
        prod_next      = prod_reg;
        dot_next       = dot_reg;
        refl_next      = refl_reg;
        p1_next        = p1_reg;
        w1_next        = w1_reg;
        p2_next        = p2_reg;
        mac_next       = mac_reg;
        col_ok_next    = col_ok_reg;
        g_next         = g_reg;
        out_valid_next = out_valid_reg && !gains.ready;
        out_row_next   = out_row_reg;
        out_gain_next  = out_gain_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    item_next = q_item;
                    case (q_item.kind)
                        OP_LOAD_MAT:  state_next = BK_MAT;
                        OP_LOAD_ELEM: state_next = BK_ELEM_X;
                        OP_ENTRY:     state_next = BK_MAC_MUL;
                        OP_ROW_END:   state_next = BK_ROW_CHK;
                        default:      state_next = BK_IDLE;
                    endcase
                end
            end
            BK_MAT:
            begin
                state_next = BK_IDLE;
            end
            BK_ELEM_X:
            begin
                prod_next  = 32'(item_reg.normal_x) * 32'(cfg.sun_x);
                state_next = BK_ELEM_Y;
            end
            BK_ELEM_Y:
            begin
                dot_next   = 34'(prod_reg);
                prod_next  = 32'(item_reg.normal_y) * 32'(cfg.sun_y);
                state_next = BK_ELEM_Z;
            end
            BK_ELEM_Z:
            begin
                dot_next   = dot_reg + 34'(prod_reg);
                prod_next  = 32'(item_reg.normal_z) * 32'(cfg.sun_z);
                state_next = BK_ELEM_REFL;
            end
            BK_ELEM_REFL:
            begin
                dot_next = dot_reg + 34'(prod_reg);
                if (32'(item_reg.material_id) >= m_eff || refl_raw < 18'sd0)
                begin
                    refl_next = '0;
                end
                else if (refl_raw > 18'(ONE))
                begin
                    refl_next = 17'(ONE);
                end
                else
                begin
                    refl_next = refl_raw[16:0];
                end
                state_next = BK_ELEM_MUL1;
            end
            BK_ELEM_MUL1:
            begin
                p1_next    = 34'(refl_reg) * 34'(mul_a);
                state_next = BK_ELEM_MUL2;
            end
            BK_ELEM_MUL2:
            begin
                w1_next    = 20'((p1_reg + 34'(HALF)) >> FRAC_BITS);
                p2_next    = 36'(20'((p1_reg + 34'(HALF)) >> FRAC_BITS)) *
                             36'(item_reg.visibility);
                state_next = BK_ELEM_WR;
            end
            BK_ELEM_WR:
            begin
                state_next = BK_IDLE;
            end
            BK_MAC_MUL:
            begin
                mac_next    = 32'(item_reg.view_factor) * 32'(weight_rd_reg);
                col_ok_next = 32'(item_reg.column_index) < n_eff;
                state_next  = BK_MAC_ACC;
            end
            BK_MAC_ACC:
            begin
                if (col_ok_reg)
                begin
                    acc_next = (acc_sum > (ACC_W+1)'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
                end
                state_next = BK_IDLE;
            end
            BK_ROW_CHK:
            begin
                if (32'(row_reg) >= n_eff)
                begin
                    acc_next   = '0;
                    row_next   = '0;
                    state_next = BK_IDLE;
                end
                else
                begin
                    g_next     = (g_sum > 35'(GAIN_MAX)) ? GAIN_MAX : g_sum[31:0];
                    state_next = BK_ROW_EMIT;
                end
            end
            BK_ROW_EMIT:
            begin
                // Hold until the output register is free, then emit and advance the row.
                if (!out_valid_reg || gains.ready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_addr_ext[11:0];
                    out_gain_next  = g_reg;
                    acc_next       = '0;
                    row_next       = (32'(row_reg) + 32'd1 >= n_eff) ? '0 : row_reg + 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            acc_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        dot_reg      <= dot_next;
        refl_reg     <= refl_next;
        p1_reg       <= p1_next;
        w1_reg       <= w1_next;
        p2_reg       <= p2_next;
        mac_reg      <= mac_next;
        col_ok_reg   <= col_ok_next;
        g_reg        <= g_next;
        out_row_reg  <= out_row_next;
        out_gain_reg <= out_gain_next;
    end

    // Stores: registered reads, from the queue head at pop time but sky from the current row.
    always_ff @(posedge clk)
    begin
        if (mat_wr)
        begin
            absorb_mem[slot_ext[MAW-1:0]] <= item_reg.absorptivity;
        end
        if (elem_wr)
        begin
            weight_mem[slot_ext[EAW-1:0]] <= weight_wr;
            sky_mem[slot_ext[EAW-1:0]]    <= item_reg.sky_fraction;
        end
        // Hold the popped item's reads while its steps run.
        if (pop)
        begin
            absorb_rd_reg <= absorb_mem[mat_addr_ext[MAW-1:0]];
            weight_rd_reg <= weight_mem[col_addr_ext[EAW-1:0]];
        end
        sky_rd_reg    <= sky_mem[row_addr_ext[EAW-1:0]];
    end
endmodule
`default_nettype wire

/* rtl/view_factor_gain_accumulator.sv */
// Top level of the view-factor gain accumulator: config registers, front and back.
// Depends on vfga_pkg, vfga_if, vfga_front and vfga_back.
`default_nettype none
// View-factor gain accumulator. Load materials (operation 0) and elements
// (operation 1), then stream a view-factor matrix in row order: each in-range
// matrix entry (operation 2) adds view_factor times the column's stored weight
// to the row sum, and each row end (operation 3) for a row in use emits one
// Q16.15 gain beat for the current row, then advances the row, wrapping to
// zero after the last element in use. A front queue of two beats accepts items
// while the back sequencer works, so item ready stays high until the queue
// fills. The back sequencer takes one item at a time with a single multiplier
// per step: a material load is a pop and a write, an element load a pop, three
// dot-product steps, reflectance, two scaling products and a write, a matrix
// entry a weight read, a multiply and a saturating add, and a row end a pop, a
// check and an emit plus any wait on gain ready. Sustained rate is set by
// these steps. Element weights use gain_mode and the sun registers as they
// stand at load time. Stores hold no reset value: read only what was loaded.
// There is no clearing pass. Write configuration only while the block is idle.
module view_factor_gain_accumulator
    import vfga_pkg::*;
#(
    parameter int MAX_ELEMENTS  = DEF_MAX_ELEMENTS,
    parameter int MAX_MATERIALS = DEF_MAX_MATERIALS
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    vfga_item_if.sink        item_ch,
    vfga_gain_if.source      gain_ch,
    input  wire logic        cfg_wen,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    cfg_t  cfg_reg, cfg_next;
    logic  q_valid;
    item_t q_item;
    logic  pop;

    // Decode config writes; indexes beyond the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GAIN_MODE:      cfg_next.gain_mode      = cfg_data[0];
                CFG_ELEMENT_COUNT:  cfg_next.element_count  = cfg_data[12:0];
                CFG_MATERIAL_COUNT: cfg_next.material_count = cfg_data[8:0];
                CFG_SUN_X:          cfg_next.sun_x          = cfg_data;
                CFG_SUN_Y:          cfg_next.sun_y          = cfg_data;
                CFG_SUN_Z:          cfg_next.sun_z          = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept and classify beats into the queue.
    vfga_front #(
        .MAX_ELEMENTS  (MAX_ELEMENTS),
        .MAX_MATERIALS (MAX_MATERIALS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .pop     (pop),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    // Back: run each queued item against the stores and drive gain beats.
    vfga_back #(
        .MAX_ELEMENTS  (MAX_ELEMENTS),
        .MAX_MATERIALS (MAX_MATERIALS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .gains   (gain_ch)
    );
endmodule
`default_nettype wire

/* rtl/vfga_checker.sv */
// Port-level checker for the view-factor gain accumulator, bound to the top level.
// Depends on view_factor_gain_accumulator_defines.svh.
`default_nettype none
`include "view_factor_gain_accumulator_defines.svh"
module vfga_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        gain_valid,
    input wire logic        gain_ready,
    input wire logic [11:0] gain_row,
    input wire logic [31:0] gain_value
);
    `VFGA_ASSERT_NEXT(a_gain_hold, gain_valid && !gain_ready, gain_valid && $stable(gain_value) && $stable(gain_row))
    `VFGA_ASSERT_IMPL(a_gain_nonneg, gain_valid, !gain_value[31])
    `VFGA_ASSERT_IMPL(a_no_beat_after_reset, $past(!rst_n), !gain_valid)
endmodule

bind view_factor_gain_accumulator vfga_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .gain_valid (gain_ch.valid),
    .gain_ready (gain_ch.ready),
    .gain_row   (gain_ch.row_index),
    .gain_value (gain_ch.gain)
);
`default_nettype wire
